@@ design/tss_pkg.sv @@
// tss_pkg: shared types, widths and constants for the Maclaurin series block.
// No dependencies.
package tss_pkg;

    localparam int MAX_TERMS_DEF = 16;
    localparam int FRAC_BITS_DEF = 28;

    localparam int X_W       = 32;
    localparam int SUM_W     = 41;
    localparam int FSEL_W    = 2;
    localparam int NTERMS_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam int DQ_W      = 64;
    localparam int HALF_W    = 31;
    localparam int MP_W      = HALF_W + X_W;
    localparam int PROD_W    = MP_W + HALF_W;
    localparam int ACC_W     = 63;
    localparam int S_CAP_EXP = 61;

    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = DQ_W / DIV_BITS;
    localparam int DCNT_W     = $clog2(DIV_CYCLES);

    localparam logic [CFG_IDX_W-1:0] REG_FSEL   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NTERMS = CFG_IDX_W'(1);

    localparam logic [FSEL_W-1:0] FUNC_COS = FSEL_W'(0);
    localparam logic [FSEL_W-1:0] FUNC_SIN = FSEL_W'(1);
    localparam logic [FSEL_W-1:0] FUNC_EXP = FSEL_W'(2);

    localparam logic [FSEL_W-1:0]   FSEL_RST   = FUNC_COS;
    localparam logic [NTERMS_W-1:0] NTERMS_RST = NTERMS_W'(10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic scale;
        logic prep;
        logic div;
        logic acc;
        logic load_out;
    } t_dp_cmd;

    // derivative at zero: +1, 0 or -1 by function and phase i mod 4
    function automatic logic signed [1:0] coef(input logic [FSEL_W-1:0] sel,
                                               input logic [1:0] ph);
        logic signed [1:0] d;
        d = 2'sd0;
        case (sel)
            FUNC_COS: begin
                if (ph == 2'd0) d = 2'sd1;
                else if (ph == 2'd2) d = -2'sd1;
            end
            FUNC_SIN: begin
                if (ph == 2'd1) d = 2'sd1;
                else if (ph == 2'd3) d = -2'sd1;
            end
            FUNC_EXP: d = 2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

@@ design/tss_in_if.sv @@
// tss_in_if: input channel, one argument word per handshake.
// Depends on tss_pkg.
interface tss_in_if;
    import tss_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [X_W-1:0]   arg_x;
    modport source(output valid, output arg_x, input ready);
    modport sink(input valid, input arg_x, output ready);
endinterface

@@ design/tss_out_if.sv @@
// tss_out_if: result channel, one series sum word per handshake.
// Depends on tss_pkg.
interface tss_out_if;
    import tss_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] series_sum;
    logic                    saturated;
    modport source(output valid, output series_sum, output saturated, input ready);
    modport sink(input valid, input series_sum, input saturated, output ready);
endinterface

@@ design/tss_ctrl.sv @@
// tss_ctrl: sequencer for term recurrence, handshakes and output valid.
// Depends on tss_pkg.
module tss_ctrl #(
    parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF,
    parameter int CW        = $clog2(MAX_TERMS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tss_pkg::NTERMS_W-1:0]  i_nterms,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output tss_pkg::t_dp_cmd              o_cmd,
    output logic [CW-1:0]                 o_idx
);
    import tss_pkg::*;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_n, n_n;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic                r_ovalid, n_ovalid;
    logic [CW-1:0]       n_eff;
    logic                accept;

    always_comb begin
        if (int'(i_nterms) > MAX_TERMS) n_eff = CW'(MAX_TERMS);
        else n_eff = CW'(i_nterms);
    end

    assign accept = i_in_valid && (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (accept) n_state = (n_eff == '0) ? ST_DONE : ST_ACC;
            ST_ACC:    n_state = (r_i == r_n - CW'(1)) ? ST_DONE : ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_PREP;
            ST_PREP:   n_state = ST_DIV;
            ST_DIV:    if (r_dcnt == DCNT_W'(DIV_CYCLES - 1)) n_state = ST_ACC;
            ST_DONE:   if (!r_ovalid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = accept;
            end
            ST_ACC:    o_cmd.acc = 1'b1;
            ST_MUL_LO: o_cmd.mul_lo = 1'b1;
            ST_MUL_HI: o_cmd.mul_hi = 1'b1;
            ST_SCALE:  o_cmd.scale = 1'b1;
            ST_PREP:   o_cmd.prep = 1'b1;
            ST_DIV:    o_cmd.div = 1'b1;
            ST_DONE:   o_cmd.load_out = !r_ovalid || i_out_ready;
            default:   o_cmd = '0;
        endcase
    end

    always_comb begin
        n_i      = r_i;
        n_n      = r_n;
        n_dcnt   = r_dcnt;
        n_ovalid = r_ovalid;
        if (o_cmd.load) begin
            n_i = '0;
            n_n = n_eff;
        end
        if (o_cmd.acc) n_i = r_i + CW'(1);
        if (o_cmd.prep) n_dcnt = '0;
        if (o_cmd.div) n_dcnt = r_dcnt + DCNT_W'(1);
        if (o_cmd.load_out) n_ovalid = 1'b1;
        else if (i_out_ready) n_ovalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_i      <= '0;
            r_n      <= '0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_n      <= n_n;
            r_dcnt   <= n_dcnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_idx       = r_i;

endmodule

@@ design/tss_dp.sv @@
// tss_dp: term register, shared 31x32 multiplier, scale/cap, digit divider,
// accumulator with clamp and output register. Depends on tss_pkg.
module tss_dp #(
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF,
    parameter int CW        = 5
) (
    input  logic                              i_clk,
    input  tss_pkg::t_dp_cmd                  i_cmd,
    input  logic [CW-1:0]                     i_idx,
    input  logic [tss_pkg::FSEL_W-1:0]        i_fsel,
    input  logic signed [tss_pkg::X_W-1:0]    i_arg_x,
    output logic signed [tss_pkg::SUM_W-1:0]  o_sum,
    output logic                              o_sat
);
    import tss_pkg::*;

    localparam logic signed [DQ_W-1:0] ACC_LIM = DQ_W'(64'h2000_0000_0000_0000);
    localparam logic signed [DQ_W-1:0] OUT_MAX = DQ_W'(64'h0000_00FF_FFFF_FFFF);
    localparam logic signed [DQ_W-1:0] OUT_MIN = -DQ_W'(64'h0000_0100_0000_0000);
    localparam logic [DQ_W-1:0]        S_CAP   = DQ_W'(1) << S_CAP_EXP;

    logic [DQ_W-1:0]          r_dq;
    logic [CW-1:0]            r_rem;
    logic [X_W-1:0]           r_xmag;
    logic                     r_xneg;
    logic                     r_tneg;
    logic [MP_W-1:0]          r_plo, r_phi;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_sat;
    logic signed [SUM_W-1:0]  r_osum;
    logic                     r_osat;

    logic [HALF_W-1:0]        mul_a;
    logic [MP_W-1:0]          mul_p;
    logic [PROD_W-1:0]        prod, sr;
    logic [DQ_W-1:0]          dq_d;
    logic [CW-1:0]            rem_d;
    logic [CW:0]              r2;
    logic signed [1:0]        d;
    logic                     neg;
    logic signed [DQ_W-1:0]   tm, sum, acc_x;

    assign mul_a = i_cmd.mul_hi ? r_dq[2*HALF_W-1:HALF_W] : r_dq[HALF_W-1:0];
    assign mul_p = MP_W'(mul_a) * MP_W'(r_xmag);

    assign prod = {r_phi, HALF_W'(0)} + PROD_W'(r_plo);
    assign sr   = prod >> (FRAC_BITS - 1);

    // eight quotient bits per cycle, divisor is the term index
    always_comb begin
        rem_d = r_rem;
        dq_d  = r_dq;
        r2    = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            r2   = {rem_d, dq_d[DQ_W-1]};
            dq_d = {dq_d[DQ_W-2:0], 1'b0};
            if (r2 >= {1'b0, i_idx}) begin
                dq_d[0] = 1'b1;
                r2      = r2 - {1'b0, i_idx};
            end
            rem_d = r2[CW-1:0];
        end
    end

    always_comb begin
        d     = coef(i_fsel, 2'(i_idx));
        neg   = (d < 0) ^ r_tneg;
        tm    = $signed({2'b00, r_dq[DQ_W-3:0]});
        acc_x = DQ_W'(r_acc);
        sum   = acc_x + (neg ? -tm : tm);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dq   <= DQ_W'(1) << FRAC_BITS;
            r_xneg <= i_arg_x[X_W-1];
            r_xmag <= i_arg_x[X_W-1] ? (~i_arg_x + X_W'(1)) : i_arg_x;
            r_tneg <= 1'b0;
            r_acc  <= '0;
            r_sat  <= 1'b0;
        end
        if (i_cmd.mul_lo) r_plo <= mul_p;
        if (i_cmd.mul_hi) r_phi <= mul_p;
        if (i_cmd.scale) begin
            if (|sr[PROD_W-1:S_CAP_EXP]) begin
                r_dq  <= S_CAP;
                r_sat <= 1'b1;
            end else begin
                r_dq <= sr[DQ_W-1:0];
            end
        end
        if (i_cmd.prep) begin
            r_dq   <= (r_dq + DQ_W'(i_idx)) >> 1;
            r_rem  <= '0;
            r_tneg <= r_tneg ^ r_xneg;
        end
        if (i_cmd.div) begin
            r_dq  <= dq_d;
            r_rem <= rem_d;
        end
        if (i_cmd.acc && d != 2'sd0) begin
            if (sum > ACC_LIM) begin
                r_acc <= ACC_W'(ACC_LIM);
                r_sat <= 1'b1;
            end else if (sum < -ACC_LIM) begin
                r_acc <= ACC_W'(-ACC_LIM);
                r_sat <= 1'b1;
            end else begin
                r_acc <= sum[ACC_W-1:0];
            end
        end
        if (i_cmd.load_out) begin
            if (acc_x > OUT_MAX) begin
                r_osum <= OUT_MAX[SUM_W-1:0];
                r_osat <= 1'b1;
            end else if (acc_x < OUT_MIN) begin
                r_osum <= OUT_MIN[SUM_W-1:0];
                r_osat <= 1'b1;
            end else begin
                r_osum <= acc_x[SUM_W-1:0];
                r_osat <= r_sat;
            end
        end
    end

    assign o_sum = r_osum;
    assign o_sat = r_osat;

endmodule

@@ design/taylor_series_sin_cos_exp.sv @@
// taylor_series_sin_cos_exp: top level, config registers, controller and datapath.
// Depends on tss_pkg, tss_in_if, tss_out_if, tss_ctrl, tss_dp.
//
//   channel   dir   payload                       word
//   i_in      in    arg_x Q3.28                   one argument
//   o_out     out   series_sum Q12.28, saturated  one result
//   cfg       in    i_cfg_idx, i_cfg_data         one register write
//
// Each term after the first passes in order through the shared 31x32 multiplier
// (low, then high half of the term), scale and round, the divider (8 quotient
// bits a cycle) and the accumulator; with no terms an item goes straight to the
// result. The result word turns valid as the controller returns to idle. One item
// at a time; the next is taken once the result is in the output register.
// Reset: function cos, 10 terms.
module taylor_series_sin_cos_exp #(
    parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tss_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    tss_in_if.sink                          i_in,
    tss_out_if.source                       o_out
);
    import tss_pkg::*;

    localparam int CW = $clog2(MAX_TERMS + 1);

    logic [FSEL_W-1:0]   r_fsel;
    logic [NTERMS_W-1:0] r_nterms;
    t_dp_cmd             cmd;
    logic [CW-1:0]       idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel   <= FSEL_RST;
            r_nterms <= NTERMS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FSEL:   r_fsel   <= i_cfg_data[FSEL_W-1:0];
                REG_NTERMS: r_nterms <= i_cfg_data[NTERMS_W-1:0];
                default: ;
            endcase
        end
    end

    tss_ctrl #(
        .MAX_TERMS (MAX_TERMS),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nterms    (r_nterms),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .o_idx       (idx)
    );

    tss_dp #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_idx   (idx),
        .i_fsel  (r_fsel),
        .i_arg_x (i_in.arg_x),
        .o_sum   (o_out.series_sum),
        .o_sat   (o_out.saturated)
    );

endmodule

@@ design/tss_checker.sv @@
// tss_checker: port-level checks on the series block, bound to the top level.
// Depends on taylor_series_sin_cos_exp.
module tss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [40:0] i_sum,
    input logic        i_sat
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while word in flight");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result word without work");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_sum) && $stable(i_sat))
        else $error("stalled result word changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind taylor_series_sin_cos_exp tss_checker u_tss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sum       (o_out.series_sum),
    .i_sat       (o_out.saturated)
);

@@ sim/tb_taylor_series_sin_cos_exp.sv @@
`timescale 1ns / 100ps
// tb_taylor_series_sin_cos_exp: self-checking bench for the cos/sin/exp series block.
// Predicts each result word in-bench and compares it with the output channel.
// Depends on tss_pkg, tss_in_if, tss_out_if and taylor_series_sin_cos_exp.
module tb_taylor_series_sin_cos_exp;
    import tss_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 1630;
    localparam int HOLD_CYCLES    = 600;
    localparam int CFG_SETTLE     = 4;
    localparam int END_DRAIN      = 250;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = CFG_IDX_W'(3);
    localparam logic [FSEL_W-1:0]    FUNC_NONE  = FSEL_W'(3);

    localparam logic signed [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};
    localparam logic signed [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};
    localparam logic signed [X_W-1:0] X_ONE = X_W'(1) <<< FRAC_BITS_DEF;

    localparam logic [127:0] S_CAP   = 128'd1 << S_CAP_EXP;
    localparam longint       ACC_LIM = longint'(1) <<< S_CAP_EXP;
    localparam longint       OUT_MAX = (longint'(1) <<< (SUM_W-1)) - 1;
    localparam longint       OUT_MIN = -(longint'(1) <<< (SUM_W-1));

    typedef struct packed {
        logic signed [SUM_W-1:0] series_sum;
        logic                    saturated;
    } t_series_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    tss_in_if  in_if();
    tss_out_if out_if();

    taylor_series_sin_cos_exp dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    logic [FSEL_W-1:0]   series_fsel;
    logic [NTERMS_W-1:0] series_nterms;
    t_series_word        series_due_q[$];
    t_series_word        due_word;
    int                  fail_cnt   = 0;
    int                  burst_left = 0;
    bit                  pace_on    = 1'b1;
    logic                hold_off_req = 1'b0;

    function automatic int term_sign(input logic [FSEL_W-1:0] fsel, input logic [1:0] ph);
        int d;
        case (fsel)
            FUNC_COS: d = ph[0] ? 0 : (ph[1] ? -1 : 1);
            FUNC_SIN: d = ph[0] ? (ph[1] ? -1 : 1) : 0;
            FUNC_EXP: d = 1;
            default:  d = 0;
        endcase
        return d;
    endfunction

    function automatic t_series_word predict_series(input logic signed [X_W-1:0] x);
        logic         xneg;
        logic [31:0]  xmag;
        logic [63:0]  tmag;
        logic         tneg;
        logic         sat;
        logic [127:0] scaled;
        logic [63:0]  s;
        longint       acc;
        longint       t;
        int           n;
        int           d;
        t_series_word r;
        xneg = x[X_W-1];
        xmag = xneg ? (~x + 1'b1) : x;
        n    = (series_nterms > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(series_nterms);
        tmag = 64'd1 << FRAC_BITS_DEF;
        tneg = 1'b0;
        sat  = 1'b0;
        acc  = 0;
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                scaled = (128'(tmag) * 128'(xmag)) >> (FRAC_BITS_DEF - 1);
                if (scaled >= S_CAP) begin
                    s   = S_CAP[63:0];
                    sat = 1'b1;
                end else begin
                    s = scaled[63:0];
                end
                tmag = (s + 64'(i)) / 64'(2 * i);
                tneg = tneg ^ xneg;
            end
            d = term_sign(series_fsel, 2'(i));
            if (d != 0) begin
                t = $signed(tmag);
                if ((d < 0) != tneg) t = -t;
                acc += t;
                if (acc > ACC_LIM) begin
                    acc = ACC_LIM;
                    sat = 1'b1;
                end else if (acc < -ACC_LIM) begin
                    acc = -ACC_LIM;
                    sat = 1'b1;
                end
            end
        end
        if (acc > OUT_MAX) begin
            acc = OUT_MAX;
            sat = 1'b1;
        end else if (acc < OUT_MIN) begin
            acc = OUT_MIN;
            sat = 1'b1;
        end
        r.series_sum = acc[SUM_W-1:0];
        r.saturated  = sat;
        return r;
    endfunction

    function automatic logic signed [X_W-1:0] rand_arg();
        logic signed [X_W-1:0] r;
        int                    pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r = $urandom;
        end else if (pick < 70) begin
            r = $urandom_range(0, 32'h1000_0000);
            if ($urandom_range(0, 1)) r = -r;
        end else if (pick < 85) begin
            r = $urandom_range(0, 1) ? X_MAX - $urandom_range(0, 255)
                                     : X_MIN + $urandom_range(0, 255);
        end else begin
            r = X_W'(1) <<< $urandom_range(0, 30);
            if ($urandom_range(0, 1)) r = -r;
        end
        return r;
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_terms();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return CFG_DAT_W'($urandom_range(0, 6));
        if (pick < 85) return CFG_DAT_W'($urandom_range(7, 16));
        return CFG_DAT_W'($urandom_range(17, 31));
    endfunction

    task automatic pause_sender(input int n);
        in_if.valid <= 1'b0;
        in_if.arg_x <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        if (!pace_on) return;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            pause_sender($urandom_range(1, 30));
        end
        burst_left--;
    endtask

    task automatic send_arg(input logic signed [X_W-1:0] x);
        pace_sender();
        in_if.valid <= 1'b1;
        in_if.arg_x <= x;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        series_due_q.push_back(predict_series(x));
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (series_due_q.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_FSEL:   series_fsel   = data[FSEL_W-1:0];
            REG_NTERMS: series_nterms = data[NTERMS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DAT_W-1:0] fsel_dat,
                              input logic [CFG_DAT_W-1:0] nterms_dat);
        wait_idle();
        write_reg(REG_FSEL, fsel_dat);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3, CFG_DAT_W'($urandom));
        write_reg(REG_NTERMS, nterms_dat);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_config();
        send_arg('0);
        send_arg(X_MAX);
        send_arg(X_MIN);
    endtask

    task automatic test_each_function();
        set_config(CFG_DAT_W'(FUNC_COS), CFG_DAT_W'(16));
        send_arg(X_MAX);
        send_arg(X_MIN);
        send_arg(X_ONE);
        set_config(CFG_DAT_W'(FUNC_SIN), CFG_DAT_W'(16));
        send_arg(X_MAX);
        send_arg(X_MIN);
        send_arg(-X_ONE);
        set_config(CFG_DAT_W'(FUNC_EXP), CFG_DAT_W'(16));
        send_arg(X_MAX);
        send_arg(X_MIN);
        send_arg(X_ONE);
        set_config(CFG_DAT_W'(FUNC_NONE), CFG_DAT_W'(16));
        send_arg(X_MAX);
    endtask

    task automatic test_term_limits();
        set_config(CFG_DAT_W'(FUNC_EXP), CFG_DAT_W'(0));
        send_arg(X_MAX);
        set_config(CFG_DAT_W'(FUNC_EXP), CFG_DAT_W'(1));
        send_arg(X_MIN);
        set_config(CFG_DAT_W'(FUNC_SIN), CFG_DAT_W'(31));
        send_arg(X_MAX);
        set_config(CFG_DAT_W'(FUNC_COS), CFG_DAT_W'(17));
        send_arg(-X_ONE);
    endtask

    task automatic test_register_masking();
        // upper data bits dropped on the function register
        set_config(5'b11110, CFG_DAT_W'(5));
        wait_idle();
        write_reg(REG_SPARE2, 5'b11111);
        write_reg(REG_SPARE3, 5'b00000);
        i_cfg_we <= 1'b0;
        send_arg(X_ONE);
        set_config(5'b11111, CFG_DAT_W'(9));
        send_arg(X_ONE);
    endtask

    task automatic test_output_hold();
        set_config(CFG_DAT_W'(FUNC_SIN), CFG_DAT_W'(2));
        hold_off_req <= 1'b1;
        pace_on = 1'b0;
        repeat (12) send_arg(rand_arg());
        pace_on = 1'b1;
    endtask

    task automatic test_random_args();
        int sent;
        int batch;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_config(CFG_DAT_W'($urandom), pick_terms());
            batch = $urandom_range(20, 60);
            repeat (batch) send_arg(rand_arg());
            sent += batch;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (series_due_q.size() == 0) begin
                $error("unexpected word: series_sum=%0d saturated=%0b",
                       out_if.series_sum, out_if.saturated);
                fail_cnt++;
            end else begin
                due_word = series_due_q.pop_front();
                if (out_if.series_sum !== due_word.series_sum) begin
                    $error("series_sum: expected %0d, actual %0d",
                           due_word.series_sum, out_if.series_sum);
                    fail_cnt++;
                end
                if (out_if.saturated !== due_word.saturated) begin
                    $error("saturated: expected %0b, actual %0b",
                           due_word.saturated, out_if.saturated);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin : result_sink
        int pct;
        int seg;
        bit hold_done;
        pct = 0;
        seg = 0;
        hold_done = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (seg == 0) begin
                    seg = $urandom_range(16, 160);
                    case ($urandom_range(0, 4))
                        0, 1:    pct = 0;
                        2:       pct = 30;
                        3:       pct = 60;
                        default: pct = 85;
                    endcase
                end
                seg--;
                out_if.ready <= ($urandom_range(0, 99) >= pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) || i_cfg_we === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_taylor_series_sin_cos_exp NOT OK");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_FSEL;
        i_cfg_data  = '0;
        in_if.valid = 1'b0;
        in_if.arg_x = '0;
        series_fsel   = FSEL_RST;
        series_nterms = NTERMS_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_each_function();
        test_term_limits();
        test_register_masking();
        test_output_hold();
        test_random_args();

        wait_idle();
        repeat (END_DRAIN) @(posedge i_clk);
        if (fail_cnt == 0 && series_due_q.size() == 0)
            $display("tb_taylor_series_sin_cos_exp OK");
        else
            $display("tb_taylor_series_sin_cos_exp NOT OK");
        $finish;
    end

endmodule
